>>> design/wtpr_pkg.sv
// Shared constants for the watchdog timeout to prescale reload unit.
`timescale 1ns / 1ps

package wtpr_pkg;

   // Field widths.
   localparam int LSI_W     = 18;
   localparam int TIMEOUT_W = 20;
   localparam int CODE_W    = 3;
   localparam int RELOAD_W  = 12;
   localparam int ACTUAL_W  = 22;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 1;

   // Product of counter frequency and timeout.
   localparam int PROD_W = LSI_W + TIMEOUT_W;

   // The shared divider works on dividends of the actual-timeout width.
   localparam int DIV_W = ACTUAL_W;

   // Multiplier digit size in bits.
   localparam int DIGIT_W = 4;

   // Behavioural constants.
   localparam int unsigned RELOAD_MAX        = 4095;
   localparam int unsigned TOP_PRESCALE_CODE = 6;
   localparam int unsigned MS_PER_S          = 1000;

   // A reload fits exactly when the product is below (RELOAD_MAX + 1) * 1000.
   localparam logic [PROD_W-1:0] FIT_LIMIT = PROD_W'((RELOAD_MAX + 1) * MS_PER_S);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LSI_FREQ    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TIMEOUT = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [LSI_W-1:0]     LSI_RESET  = 18'd32000;
   localparam logic [TIMEOUT_W-1:0] MAXT_RESET = 20'd32760;

   // Status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage

>>> design/wtpr_mul.sv
// Digit-serial shift-and-add multiplier, four multiplier bits per cycle.
`timescale 1ns / 1ps

module wtpr_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [wtpr_pkg::LSI_W-1:0]         multiplicand,
   input  logic [wtpr_pkg::TIMEOUT_W-1:0]     multiplier,
   output logic                               done,
   output logic [wtpr_pkg::PROD_W-1:0]        product
);
   import wtpr_pkg::*;

   localparam int STEPS = (TIMEOUT_W + DIGIT_W - 1) / DIGIT_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int SH_W  = STEPS * DIGIT_W;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [PROD_W-1:0]         acc_ff, acc_in;
   logic [SH_W-1:0]           sh_ff, sh_in;
   logic [LSI_W-1:0]          mcand_ff, mcand_in;
   logic [LSI_W+DIGIT_W-1:0]  partial;

   assign partial = {{DIGIT_W{1'b0}}, mcand_ff} * {{LSI_W{1'b0}}, sh_ff[SH_W-1 -: DIGIT_W]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(STEPS);
         acc_in   = '0;
         sh_in    = SH_W'(multiplier);
         mcand_in = multiplicand;
      end else if (busy_ff) begin
         // Most significant digit first: shift the sum up and add the next partial product.
         acc_in = (acc_ff << DIGIT_W) + PROD_W'(partial);
         sh_in  = sh_ff << DIGIT_W;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> design/wtpr_div.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module wtpr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wtpr_pkg::DIV_W-1:0]    dividend,
   input  logic [wtpr_pkg::LSI_W-1:0]    divisor,
   output logic                          done,
   output logic [wtpr_pkg::DIV_W-1:0]    quotient
);
   import wtpr_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LSI_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [LSI_W-1:0]     dvs_ff, dvs_in;
   logic [LSI_W:0]       shifted;
   logic [LSI_W+1:0]     trial;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it always fits LSI_W bits.
         if (trial[LSI_W+1]) begin
            rem_in = shifted[LSI_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial[LSI_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/watchdog_timeout_to_prescale_reload_unit.sv
// Top level: turns a watchdog timeout in milliseconds into prescaler code, reload and achieved timeout.
`timescale 1ns / 1ps

// One request transaction yields one response transaction. The prescaler search tries codes from
// zero upwards, each in the four-bit-per-cycle multiplier; the reload (product divided by 1000)
// and the achieved timeout (1000 times reload divided by the counter frequency) then each take a
// pass through the shared one-bit-per-cycle divider. A reload saturated at the top code skips the
// first division, a zero counter frequency skips the second, and an out-of-range request goes
// straight to the done state, from which its response is registered. The unit is ready for the
// next request from the cycle after its response has been loaded, so it handles one request at
// a time; while an earlier response still waits on the output, the finished one is held back
// until it leaves. Configuration writes are taken at any time but must only be issued while no
// request is in flight.
module watchdog_timeout_to_prescale_reload_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Request: timeout_ms in bits 19:0.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,
   // Response tdata: prescale_code [2:0], reload_value [14:3], actual_timeout_ms [36:15].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,
   // Response tuser: status [0].
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wtpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wtpr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import wtpr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIVR,
      S_DIVA,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [LSI_W-1:0]        lsi_ff, lsi_in;
   logic [TIMEOUT_W-1:0]    maxt_ff, maxt_in;
   logic [TIMEOUT_W-1:0]    t_ff, t_in;
   logic [LSI_W-1:0]        freq_ff, freq_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic [RELOAD_W-1:0]     reload_ff, reload_in;
   logic [ACTUAL_W-1:0]     actual_ff, actual_in;
   logic                    status_ff, status_in;
   logic                    mul_start_ff, mul_start_in;
   logic                    div_start_ff, div_start_in;
   logic [DIV_W-1:0]        dividend_ff, dividend_in;
   logic [LSI_W-1:0]        divisor_ff, divisor_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [39:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   logic                    mul_done;
   logic [PROD_W-1:0]       product;
   logic                    div_done;
   logic [DIV_W-1:0]        quotient;
   logic [TIMEOUT_W-1:0]    req_timeout;

   // Multiplying by 1000 as 1024 - 16 - 8.
   function automatic logic [DIV_W-1:0] times_ms(input logic [RELOAD_W-1:0] r);
      logic [DIV_W-1:0] w;
      w = DIV_W'(r);
      return (w << 10) - (w << 4) - (w << 3);
   endfunction

   wtpr_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplicand (freq_ff),
      .multiplier   (t_ff),
      .done         (mul_done),
      .product      (product)
   );

   wtpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_timeout = req_tdata[TIMEOUT_W-1:0];
   assign req_tready  = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;

   always_comb begin
      state_in     = state_ff;
      lsi_in       = lsi_ff;
      maxt_in      = maxt_ff;
      t_in         = t_ff;
      freq_in      = freq_ff;
      code_in      = code_ff;
      reload_in    = reload_ff;
      actual_in    = actual_ff;
      status_in    = status_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LSI_FREQ:    lsi_in  = csr_data[LSI_W-1:0];
            CSR_MAX_TIMEOUT: maxt_in = csr_data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               t_in      = req_timeout;
               code_in   = '0;
               freq_in   = lsi_ff >> 2;
               reload_in = '0;
               actual_in = '0;
               if (req_timeout == '0 || req_timeout > maxt_ff) begin
                  status_in = STATUS_RANGE;
                  state_in  = S_DONE;
               end else begin
                  status_in    = STATUS_OK;
                  mul_start_in = 1'b1;
                  state_in     = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               if (product < FIT_LIMIT) begin
                  dividend_in  = product[DIV_W-1:0];
                  divisor_in   = LSI_W'(MS_PER_S);
                  div_start_in = 1'b1;
                  state_in     = S_DIVR;
               end else if (code_ff == CODE_W'(TOP_PRESCALE_CODE)) begin
                  // Saturated at the top code; the frequency is non-zero here.
                  reload_in    = RELOAD_W'(RELOAD_MAX);
                  dividend_in  = times_ms(RELOAD_W'(RELOAD_MAX));
                  divisor_in   = freq_ff;
                  div_start_in = 1'b1;
                  state_in     = S_DIVA;
               end else begin
                  code_in      = code_ff + CODE_W'(1);
                  freq_in      = freq_ff >> 1;
                  mul_start_in = 1'b1;
               end
            end
         end
         S_DIVR: begin
            if (div_done) begin
               reload_in = quotient[RELOAD_W-1:0];
               if (freq_ff == '0) begin
                  actual_in = '0;
                  state_in  = S_DONE;
               end else begin
                  dividend_in  = times_ms(quotient[RELOAD_W-1:0]);
                  divisor_in   = freq_ff;
                  div_start_in = 1'b1;
                  state_in     = S_DIVA;
               end
            end
         end
         S_DIVA: begin
            if (div_done) begin
               actual_in = quotient[ACTUAL_W-1:0];
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {3'b000, actual_ff, reload_ff, code_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lsi_ff       <= LSI_RESET;
         maxt_ff      <= MAXT_RESET;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lsi_ff       <= lsi_in;
         maxt_ff      <= maxt_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      freq_ff     <= freq_in;
      code_ff     <= code_in;
      reload_ff   <= reload_in;
      actual_ff   <= actual_in;
      status_ff   <= status_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the watchdog timeout to prescale reload unit.
`timescale 1ns / 1ps

module testbench;
   import wtpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_SETTING = 56;
   localparam int SETTINGS_N = 9;

   typedef struct packed {
      logic                status;
      logic [CODE_W-1:0]   code;
      logic [RELOAD_W-1:0] reload;
      logic [ACTUAL_W-1:0] actual;
   } divider_plan_type;

   // Keeps its own copy of the two registers and the plans still owed by the block.
   class reload_scoreboard;
      logic [LSI_W-1:0]     lsi_hz;
      logic [TIMEOUT_W-1:0] limit_ms;
      divider_plan_type     owed_plans[$];
      int unsigned          failures;
      int unsigned          responses;
      int unsigned          out_of_range;
      int unsigned          stopped_counter;
      int unsigned          code_hits[7];

      function new();
         lsi_hz   = LSI_RESET;
         limit_ms = MAXT_RESET;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_LSI_FREQ) begin
            lsi_hz = value[LSI_W-1:0];
         end else begin
            limit_ms = value[TIMEOUT_W-1:0];
         end
      endfunction

      function divider_plan_type plan_timeout(logic [TIMEOUT_W-1:0] t);
         divider_plan_type  plan;
         longint unsigned   freq;
         longint unsigned   reload;
         int unsigned       c;
         plan = '0;
         if (t == 0 || t > limit_ms) begin
            plan.status = STATUS_RANGE;
            out_of_range++;
            return plan;
         end
         c = 0;
         forever begin
            freq   = 64'(lsi_hz) >> (c + 2);
            reload = freq * 64'(t) / 64'(MS_PER_S);
            if (reload <= 64'(RELOAD_MAX) || c >= TOP_PRESCALE_CODE) break;
            c++;
         end
         if (reload > 64'(RELOAD_MAX)) reload = 64'(RELOAD_MAX);
         plan.status = STATUS_OK;
         plan.code   = c[CODE_W-1:0];
         plan.reload = reload[RELOAD_W-1:0];
         // With a stopped counter clock there is nothing to divide by.
         if (freq != 0) begin
            plan.actual = ACTUAL_W'((64'(MS_PER_S) * reload) / freq);
         end else begin
            stopped_counter++;
         end
         code_hits[c]++;
         return plan;
      endfunction

      function void note_request(logic [TIMEOUT_W-1:0] t);
         owed_plans.push_back(plan_timeout(t));
      endfunction

      function void check_response(logic status, logic [39:0] data);
         divider_plan_type want;
         divider_plan_type got;
         got = {status, data[2:0], data[14:3], data[36:15]};
         responses++;
         if (owed_plans.size() == 0) begin
            $error("response with no request outstanding: status %0d code %0d reload %0d",
                   got.status, got.code, got.reload);
            failures++;
            return;
         end
         want = owed_plans.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.code !== want.code) begin
            $error("prescale_code: expected %0d, got %0d", want.code, got.code);
            failures++;
         end
         if (got.reload !== want.reload) begin
            $error("reload_value: expected %0d, got %0d", want.reload, got.reload);
            failures++;
         end
         if (got.actual !== want.actual) begin
            $error("actual_timeout_ms: expected %0d, got %0d", want.actual, got.actual);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [39:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LSI_FREQ;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   reload_scoreboard sb;
   bit               steady = 1'b0;
   int unsigned      stall_left = 0;
   int unsigned      cycle_count = 0;

   watchdog_timeout_to_prescale_reload_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Response side: each transaction is checked, then the sink may hold off for a while.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tuser, rsp_tdata);
            stall_left = steady ? 0 : $urandom_range(0, 11);
            if (stall_left != 0) rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) rsp_tready <= 1'b1;
         end
      end
   end

   // Within this task the valid line is only lowered when a gap follows, so back-to-back requests keep it high.
   task automatic send_timeout(input logic [TIMEOUT_W-1:0] t);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, t};
      do @(posedge clock); while (!req_tready);
      sb.note_request(t);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.owed_plans.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] lsi_word,
                                 input logic [CSR_DATA_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_LSI_FREQ;
      csr_data  <= lsi_word;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_LSI_FREQ, lsi_word);
      csr_index <= CSR_MAX_TIMEOUT;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_MAX_TIMEOUT, limit);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TIMEOUT_W-1:0] pick_timeout(logic [TIMEOUT_W-1:0] limit);
      logic [TIMEOUT_W-1:0] t;
      int unsigned          span;
      case ($urandom_range(0, 9))
         0: t = TIMEOUT_W'($urandom_range(0, 20'hFFFFF));
         1: t = limit + TIMEOUT_W'(1);
         2: t = limit - TIMEOUT_W'($urandom_range(0, 3));
         3: t = TIMEOUT_W'($urandom_range(0, 2));
         default: begin
            // Spread over magnitudes so that every prescale code gets its share.
            span = $urandom_range(0, TIMEOUT_W - 1);
            t = TIMEOUT_W'($urandom() & ((32'd1 << (span + 1)) - 1));
            if (t == 0 || t > limit) t = (t % limit) + TIMEOUT_W'(1);
         end
      endcase
      return t;
   endfunction

   initial begin
      int unsigned lsi_set[SETTINGS_N] = '{32'd256, 32'd262143, 32'd262143, 32'd200, 32'd0,
                                           32'd0, 32'd0, 32'd0, 32'd32000};
      int unsigned limit_set[SETTINGS_N] = '{32'd1048575, 32'd1048575, 32'd1, 32'd1048575,
                                             32'd1000, 32'd0, 32'd0, 32'd0, 32'd32760};
      int unsigned boundary[18] = '{0, 1, 2, 511, 512, 1023, 1024, 2047, 2048, 4095, 4096,
                                    8191, 8192, 16383, 16384, 32760, 32761, 1048575};
      logic [CSR_DATA_W-1:0] lsi_word;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Prescale code boundaries and range edges at the reset register values.
      foreach (boundary[i]) send_timeout(TIMEOUT_W'(boundary[i]));
      drain_responses();

      for (int s = 5; s < 8; s++) begin
         lsi_set[s]   = $urandom_range(256, 262143);
         limit_set[s] = $urandom_range(0, 1) ? $urandom_range(1, 40000)
                                             : $urandom_range(1, 20'hFFFFF);
      end

      for (int s = 0; s < SETTINGS_N; s++) begin
         // The upper data bits are beyond the frequency register and must be dropped.
         lsi_word = {2'($urandom_range(0, 3)), 18'(lsi_set[s])};
         write_settings(lsi_word, CSR_DATA_W'(limit_set[s]));
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
            send_timeout(pick_timeout(sb.limit_ms));
         end
         drain_responses();
      end

      steady = 1'b0;
      repeat (150) @(posedge clock);
      if (sb.owed_plans.size() != 0) begin
         $error("%0d responses never arrived", sb.owed_plans.size());
         sb.failures++;
      end

      $display("Checked %0d responses over %0d register settings: %0d out of range,",
               sb.responses, SETTINGS_N + 1, sb.out_of_range);
      $display("%0d with a stopped counter clock; prescale codes 0 to 6 chosen %0d %0d %0d %0d %0d %0d %0d times.",
               sb.stopped_counter, sb.code_hits[0], sb.code_hits[1], sb.code_hits[2],
               sb.code_hits[3], sb.code_hits[4], sb.code_hits[5], sb.code_hits[6]);
      if (sb.failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
